/* sv/aidt_pkg.sv */
// shared types and constants for the address/id assignment table
package aidt_pkg;

  localparam int ADDR_W = 32;
  localparam int ID_W   = 16;
  localparam int BANKS  = 16;
  localparam int LANE_W = 4;

  localparam logic OP_ASSIGN  = 1'b0;
  localparam logic OP_REVERSE = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address;
    logic [ID_W-1:0]   query_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic [ADDR_W-1:0] result_address;
    logic              hit;
    logic              newly_assigned;
    logic              table_full;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_ALLOC,
    ST_REV_RD,
    ST_REV_DATA,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_HIT,
    RES_NEW,
    RES_FULL,
    RES_REV
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     scan;
    logic     rev;
    res_sel_t res_sel;
    logic     push;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic addr_zero;
    logic used_zero;
    logic full;
    logic qid_valid;
    logic match;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

/* sv/aidt_ram.sv */
// generic single write port, single read port ram with registered read
module aidt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/aidt_datapath.sv */
// datapath: request register, id counter, banked address store, scan compare, result registers
module aidt_datapath #(
  parameter int DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  aidt_pkg::req_t      req,
  input  aidt_pkg::cmd_t      cmd,
  output aidt_pkg::status_t   status,
  input  logic                rsp_stall,
  output logic                rsp_valid,
  output aidt_pkg::rsp_t      rsp
);

  localparam int USED_W = $clog2(DEPTH + 1);
  localparam int IDX_W  = USED_W + aidt_pkg::LANE_W;
  localparam int ROWS   = (DEPTH + aidt_pkg::BANKS - 1) / aidt_pkg::BANKS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  aidt_pkg::req_t req_q;
  aidt_pkg::rsp_t res;
  aidt_pkg::rsp_t res_next;
  logic [USED_W-1:0] used;
  logic [ROW_W-1:0]  scan_row;
  logic [ROW_W-1:0]  cmp_row;
  logic              cmp_valid;
  logic              issued_all;

  logic [IDX_W-1:0]  used_ext;
  logic [IDX_W-1:0]  used_m1;
  logic [ROW_W-1:0]  last_row;
  logic [aidt_pkg::LANE_W-1:0] last_lane;
  logic [ROW_W-1:0]  wr_row;
  logic [aidt_pkg::LANE_W-1:0] wr_lane;
  logic [aidt_pkg::ID_W-1:0]   qm1;
  logic [ROW_W-1:0]  q_row;
  logic [aidt_pkg::LANE_W-1:0] q_lane;
  logic [ROW_W-1:0]  rd_row;
  logic              scan_issue;
  logic              any_match;
  logic [aidt_pkg::LANE_W-1:0] hit_lane;
  logic [aidt_pkg::ADDR_W-1:0] rd_data [aidt_pkg::BANKS];
  logic              out_free;

  assign used_ext  = IDX_W'(used);
  assign used_m1   = used_ext - IDX_W'(1);
  assign last_row  = used_m1[aidt_pkg::LANE_W +: ROW_W];
  assign last_lane = used_m1[aidt_pkg::LANE_W-1:0];
  assign wr_row    = used_ext[aidt_pkg::LANE_W +: ROW_W];
  assign wr_lane   = used_ext[aidt_pkg::LANE_W-1:0];

  assign qm1    = req_q.query_id - aidt_pkg::ID_W'(1);
  assign q_row  = qm1[aidt_pkg::LANE_W +: ROW_W];
  assign q_lane = qm1[aidt_pkg::LANE_W-1:0];

  assign scan_issue = cmd.scan && !issued_all;
  assign rd_row     = cmd.rev ? q_row : scan_row;

  for (genvar g = 0; g < aidt_pkg::BANKS; g++) begin : g_bank
    aidt_ram #(
      .WIDTH(aidt_pkg::ADDR_W),
      .DEPTH(ROWS)
    ) u_bank (
      .clk  (clk),
      .we   (cmd.res_sel == aidt_pkg::RES_NEW && wr_lane == aidt_pkg::LANE_W'(g)),
      .waddr(wr_row),
      .wdata(req_q.address),
      .raddr(rd_row),
      .rdata(rd_data[g])
    );
  end

  // lowest matching lane of the row now out of the banks
  always_comb begin
    any_match = 1'b0;
    hit_lane  = '0;
    for (int b = aidt_pkg::BANKS - 1; b >= 0; b--) begin
      if (((cmp_row != last_row) || (aidt_pkg::LANE_W'(b) <= last_lane)) &&
          rd_data[b] == req_q.address) begin
        any_match = 1'b1;
        hit_lane  = aidt_pkg::LANE_W'(b);
      end
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    status.opcode    = req_q.opcode;
    status.addr_zero = (req_q.address == '0);
    status.used_zero = (used == '0);
    status.full      = (used == USED_W'(DEPTH));
    status.qid_valid = (req_q.query_id != '0) &&
                       ({1'b0, req_q.query_id} <= (aidt_pkg::ID_W + 1)'(used));
    status.match     = cmp_valid && any_match;
    status.scan_done = cmp_valid && !any_match && (cmp_row == last_row);
    status.out_free  = out_free;
  end

  always_comb begin
    res_next = res;
    unique case (cmd.res_sel)
      aidt_pkg::RES_ZERO: begin
        res_next = '0;
      end
      aidt_pkg::RES_HIT: begin
        res_next = '0;
        res_next.result_id = aidt_pkg::ID_W'({cmp_row, hit_lane}) + aidt_pkg::ID_W'(1);
        res_next.hit = 1'b1;
      end
      aidt_pkg::RES_NEW: begin
        res_next = '0;
        res_next.result_id = aidt_pkg::ID_W'(used) + aidt_pkg::ID_W'(1);
        res_next.newly_assigned = 1'b1;
      end
      aidt_pkg::RES_FULL: begin
        res_next = '0;
        res_next.table_full = 1'b1;
      end
      aidt_pkg::RES_REV: begin
        res_next = '0;
        res_next.result_address = rd_data[q_lane];
        res_next.hit = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= req;
      scan_row <= '0;
    end else if (scan_issue && scan_row != last_row) begin
      scan_row <= scan_row + ROW_W'(1);
    end
    cmp_row <= scan_row;
    res     <= res_next;
    if (cmd.push) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      cmp_valid  <= 1'b0;
      issued_all <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      cmp_valid <= scan_issue;
      if (cmd.load) begin
        issued_all <= 1'b0;
      end else if (scan_issue && scan_row == last_row) begin
        issued_all <= 1'b1;
      end
      if (cmd.res_sel == aidt_pkg::RES_NEW) begin
        used <= used + USED_W'(1);
      end
      if (cmd.push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/aidt_ctrl.sv */
// controller state machine sequencing decode, scan, allocate and reverse reads
module aidt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  aidt_pkg::status_t status,
  output aidt_pkg::cmd_t    cmd
);

  aidt_pkg::state_t state;
  aidt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aidt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aidt_pkg::ST_IDLE: begin
        if (req_valid) state_next = aidt_pkg::ST_DECODE;
      end
      aidt_pkg::ST_DECODE: begin
        if (status.opcode == aidt_pkg::OP_REVERSE) begin
          state_next = status.qid_valid ? aidt_pkg::ST_REV_RD : aidt_pkg::ST_FINISH;
        end else if (status.addr_zero) begin
          state_next = aidt_pkg::ST_FINISH;
        end else if (status.used_zero) begin
          state_next = aidt_pkg::ST_ALLOC;
        end else begin
          state_next = aidt_pkg::ST_SCAN;
        end
      end
      aidt_pkg::ST_SCAN: begin
        if (status.match) begin
          state_next = aidt_pkg::ST_FINISH;
        end else if (status.scan_done) begin
          state_next = status.full ? aidt_pkg::ST_FINISH : aidt_pkg::ST_ALLOC;
        end
      end
      aidt_pkg::ST_ALLOC:    state_next = aidt_pkg::ST_FINISH;
      aidt_pkg::ST_REV_RD:   state_next = aidt_pkg::ST_REV_DATA;
      aidt_pkg::ST_REV_DATA: state_next = aidt_pkg::ST_FINISH;
      aidt_pkg::ST_FINISH: begin
        if (status.out_free) state_next = aidt_pkg::ST_IDLE;
      end
      default: state_next = aidt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.res_sel = aidt_pkg::RES_NONE;
    req_stall   = (state != aidt_pkg::ST_IDLE);
    unique case (state)
      aidt_pkg::ST_IDLE: begin
        cmd.load = req_valid;
      end
      aidt_pkg::ST_DECODE: begin
        if ((status.opcode == aidt_pkg::OP_REVERSE && !status.qid_valid) ||
            (status.opcode == aidt_pkg::OP_ASSIGN && status.addr_zero)) begin
          cmd.res_sel = aidt_pkg::RES_ZERO;
        end
      end
      aidt_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.match) begin
          cmd.res_sel = aidt_pkg::RES_HIT;
        end else if (status.scan_done && status.full) begin
          cmd.res_sel = aidt_pkg::RES_FULL;
        end
      end
      aidt_pkg::ST_ALLOC: begin
        cmd.res_sel = aidt_pkg::RES_NEW;
      end
      aidt_pkg::ST_REV_RD: begin
        cmd.rev = 1'b1;
      end
      aidt_pkg::ST_REV_DATA: begin
        cmd.res_sel = aidt_pkg::RES_REV;
      end
      aidt_pkg::ST_FINISH: begin
        cmd.push = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/address_id_assignment_table_core.sv */
// address/id assignment table: assign ids to addresses and resolve ids back
// after accept a request is decoded; an assign of a nonzero address to a nonempty table scans
// the 16 banks a row a cycle and ends on a hit, allocates a new id on a miss or reports table
// full; zero address or unknown id finish from decode, an empty table allocates at once, and a
// reverse lookup of a known id reads its row, then returns the bank data; an output stall
// holds the push; one transaction at a time, the next accepted the cycle after the push
// reset clears the id counter and control state; no entry beyond the issued ids is returned
module address_id_assignment_table_core #(
  parameter int DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  aidt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output aidt_pkg::rsp_t rsp
);

  aidt_pkg::cmd_t    cmd;
  aidt_pkg::status_t status;

  aidt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .status   (status),
    .cmd      (cmd)
  );

  aidt_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .status   (status),
    .rsp_stall(rsp_stall),
    .rsp_valid(rsp_valid),
    .rsp      (rsp)
  );

  // an accepted transaction holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while busy");

  // a fresh id is never handed out once the table is full
  a_no_alloc_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_sel == aidt_pkg::RES_NEW) |-> !status.full)
    else $error("allocation with full table");

  // a result only appears after the controller pushed it
  a_rsp_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.push))
    else $error("result valid without push");

  // after a push the block is ready for the next transaction
  a_ready_after_push: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> !req_stall)
    else $error("not ready after result push");

endmodule

/* bench/tb.sv */
// testbench for the address/id assignment table: directed table plus random traffic
`timescale 1ns / 1ps

module tb;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int RAND_ITEMS  = 1425;
  localparam int PHASE_LEN   = 100;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    aidt_pkg::req_t stim;
    bit             typed;
    aidt_pkg::rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  aidt_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  aidt_pkg::rsp_t rsp;

  // predictor state: address held under id k+1 sits at index k
  logic [aidt_pkg::ADDR_W-1:0] addr_by_id [TABLE_DEPTH];
  int                          ids_given = 0;

  aidt_pkg::rsp_t pending_rsp [$];
  dir_row_t       dir_rows [$];
  bit             row_typed = 1'b0;
  aidt_pkg::rsp_t row_want = '0;
  bit             mismatch_seen = 1'b0;
  int             idle_pct = 0;
  int             stall_pct = 0;

  address_id_assignment_table_core #(.DEPTH(TABLE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // expected reply for one request; updates the id table like the block does
  function automatic aidt_pkg::rsp_t assign_or_resolve(aidt_pkg::req_t r);
    aidt_pkg::rsp_t o;
    bit             found;
    o = '0;
    found = 1'b0;
    if (r.opcode == aidt_pkg::OP_REVERSE) begin
      if (r.query_id >= 1 && r.query_id <= ids_given) begin
        o.result_address = addr_by_id[IDX_W'(r.query_id - 16'd1)];
        o.hit = 1'b1;
      end
    end else if (r.address != '0) begin
      for (int k = 0; k < ids_given && !found; k++) begin
        if (addr_by_id[k] == r.address) begin
          o.result_id = aidt_pkg::ID_W'(k + 1);
          o.hit = 1'b1;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (ids_given < TABLE_DEPTH) begin
          addr_by_id[ids_given] = r.address;
          ids_given++;
          o.result_id = aidt_pkg::ID_W'(ids_given);
          o.newly_assigned = 1'b1;
        end else begin
          o.table_full = 1'b1;
        end
      end
    end
    return o;
  endfunction

  // fresh, known and zero addresses; reverse ids around the used range or random
  function automatic aidt_pkg::req_t draw_request();
    aidt_pkg::req_t r;
    int             pick;
    r.opcode = aidt_pkg::OP_ASSIGN;
    r.address = $urandom();
    r.query_id = aidt_pkg::ID_W'($urandom_range(16'hFFFF));
    pick = $urandom_range(99);
    if (pick < 35) begin
      if (r.address == '0) r.address = 32'h1;
    end else if (pick < 60) begin
      if (ids_given > 0) r.address = addr_by_id[$urandom_range(ids_given - 1)];
    end else if (pick < 65) begin
      r.address = '0;
    end else begin
      r.opcode = aidt_pkg::OP_REVERSE;
      if (pick < 85) begin
        r.query_id = aidt_pkg::ID_W'($urandom_range(ids_given + 1));
      end else if (pick >= 95) begin
        case ($urandom_range(3))
          0: r.query_id = '0;
          1: r.query_id = aidt_pkg::ID_W'(ids_given);
          2: r.query_id = aidt_pkg::ID_W'(ids_given + 1);
          default: r.query_id = 16'hFFFF;
        endcase
      end
    end
    return r;
  endfunction

  task automatic add_row(input logic op, input logic [aidt_pkg::ADDR_W-1:0] a,
                         input logic [aidt_pkg::ID_W-1:0] q, input bit typed,
                         input logic [aidt_pkg::ID_W-1:0] rid,
                         input logic [aidt_pkg::ADDR_W-1:0] raddr, input logic h,
                         input logic fresh, input logic full);
    dir_row_t row;
    row.stim = '{opcode: op, address: a, query_id: q};
    row.typed = typed;
    row.want = '{result_id: rid, result_address: raddr, hit: h, newly_assigned: fresh,
                 table_full: full};
    dir_rows.push_back(row);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(input aidt_pkg::req_t item);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!(req_valid && !req_stall));
    @(negedge clk);
  endtask

  task automatic compare_reply(input aidt_pkg::rsp_t want, input aidt_pkg::rsp_t got);
    if (got.result_id !== want.result_id) begin
      $display("%0t: result_id expected %h got %h", $time, want.result_id, got.result_id);
      mismatch_seen = 1'b1;
    end
    if (got.result_address !== want.result_address) begin
      $display("%0t: result_address expected %h got %h", $time, want.result_address,
               got.result_address);
      mismatch_seen = 1'b1;
    end
    if (got.hit !== want.hit) begin
      $display("%0t: hit expected %b got %b", $time, want.hit, got.hit);
      mismatch_seen = 1'b1;
    end
    if (got.newly_assigned !== want.newly_assigned) begin
      $display("%0t: newly_assigned expected %b got %b", $time, want.newly_assigned,
               got.newly_assigned);
      mismatch_seen = 1'b1;
    end
    if (got.table_full !== want.table_full) begin
      $display("%0t: table_full expected %b got %b", $time, want.table_full, got.table_full);
      mismatch_seen = 1'b1;
    end
  endtask

  always @(negedge clk) begin
    rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : monitor
    aidt_pkg::rsp_t guess;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        guess = assign_or_resolve(req);
        pending_rsp.push_back(row_typed ? row_want : guess);
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected transaction %h", $time, rsp);
          mismatch_seen = 1'b1;
        end else begin
          compare_reply(pending_rsp.pop_front(), rsp);
        end
      end
    end
  end

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase = '{0, 57, 0, 7};
    stall_by_phase = '{0, 0, 57, 7};

    // empty table, zero address, extremes of both fields, first ids, reverse lookups
    add_row(aidt_pkg::OP_REVERSE, '0, '0, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0);
    add_row(aidt_pkg::OP_REVERSE, '0, 16'd1, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0);
    add_row(aidt_pkg::OP_REVERSE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0);
    add_row(aidt_pkg::OP_ASSIGN, '0, 16'hFFFF, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0);
    add_row(aidt_pkg::OP_ASSIGN, 32'hFFFF_FFFF, '0, 1'b1, 16'd1, '0, 1'b0, 1'b1, 1'b0);
    add_row(aidt_pkg::OP_ASSIGN, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'd1, '0, 1'b1, 1'b0, 1'b0);
    add_row(aidt_pkg::OP_ASSIGN, 32'h1, '0, 1'b1, 16'd2, '0, 1'b0, 1'b1, 1'b0);
    add_row(aidt_pkg::OP_ASSIGN, 32'h8000_0000, 16'h8000, 1'b1, 16'd3, '0, 1'b0, 1'b1, 1'b0);
    add_row(aidt_pkg::OP_REVERSE, '0, 16'd1, 1'b1, '0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    add_row(aidt_pkg::OP_REVERSE, 32'h1234_5678, 16'd2, 1'b1, '0, 32'h1, 1'b1, 1'b0, 1'b0);
    add_row(aidt_pkg::OP_REVERSE, '0, 16'd3, 1'b1, '0, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
    add_row(aidt_pkg::OP_REVERSE, '0, 16'd4, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0);
    add_row(aidt_pkg::OP_ASSIGN, 32'h1, 16'h7FFF, 1'b1, 16'd2, '0, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 10; i++) begin
      add_row(aidt_pkg::OP_ASSIGN, 32'h0A00_0000 + i * 32'h0101_0101, 16'(i), 1'b0, '0, '0,
              1'b0, 1'b0, 1'b0);
    end
    add_row(aidt_pkg::OP_REVERSE, '0, 16'd13, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0);
    add_row(aidt_pkg::OP_ASSIGN, 32'h0A00_0000, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row_typed = dir_rows[i].typed;
      row_want = dir_rows[i].want;
      send(dir_rows[i].stim);
    end

    row_typed = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_pct = idle_by_phase[(n / PHASE_LEN) % 4];
      stall_pct = stall_by_phase[(n / PHASE_LEN) % 4];
      send(draw_request());
    end
    req_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!mismatch_seen) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
sv/aidt_pkg.sv
sv/aidt_ram.sv
sv/aidt_datapath.sv
sv/aidt_ctrl.sv
sv/address_id_assignment_table_core.sv
bench/tb.sv
